// File: sv/sse_pkg.sv
// shared constants for the smoothed speed estimator: widths, register
// indexes and reset values, sequencer step counts
// no dependencies
package sse_pkg;

    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 32;
    localparam int FRAC_W  = 16;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    // shared multiplier
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // square root and divider
    localparam int ROOT_W     = 33;
    localparam int REM_W      = 34;
    localparam int NUM_W      = 43;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int CNT_W      = 6;

    localparam logic [9:0]  MS_PER_SEC = 10'd1000;
    localparam logic [16:0] ONE_Q16    = 17'h10000;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_MIN_INTERVAL = 3'd0;
    localparam logic [IDX_W-1:0] CFG_NEW_WEIGHT   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DECAY        = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ZERO_FLOOR   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MOVING_THR   = 3'd4;

    // reset values
    localparam logic [15:0]        RST_MIN_INTERVAL = 16'd80;
    localparam logic [15:0]        RST_NEW_WEIGHT   = 16'd16384;
    localparam logic [15:0]        RST_DECAY        = 16'd60293;
    localparam logic [SPEED_W-1:0] RST_ZERO_FLOOR   = 32'd205;
    localparam logic [SPEED_W-1:0] RST_MOVING_THR   = 32'd410;

endpackage

// File: sv/sse_mul.sv
// shared unsigned multiplier with registered product
// depends on sse_pkg
module sse_mul (
    input  logic                         i_clk,
    input  logic [sse_pkg::MUL_W-1:0]    i_a,
    input  logic [sse_pkg::MUL_W-1:0]    i_b,
    output logic [sse_pkg::PROD_W-1:0]   o_p
);

    logic [sse_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {{sse_pkg::MUL_W{1'b0}}, i_a} * {{sse_pkg::MUL_W{1'b0}}, i_b};
    end

    assign o_p = r_p;

endmodule

// File: sv/smoothed_speed_estimator_unit.sv
// Smoothed speed estimator: one result item per sample item. A sample with a
// fresh measurement passes through squaring on the shared 33x33 multiplier,
// a bit-pair square root, scaling, restoring division by the time step,
// blending and the load of the result register, in that order. A zero time
// step skips the division. A sample that comes too soon only decays the
// speed; a link-down sample or the first valid one after link loss goes
// straight to the result register. The block takes one item at a time
// (o_stall high while busy) and accepts the next item while the previous
// result still waits. A new result that finds the previous one still stalled
// holds the block in its last step until that result is taken.
// Depends on sse_pkg and sse_mul.
module smoothed_speed_estimator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample items
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_link_valid,
    input  logic signed [sse_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [sse_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [sse_pkg::POS_W-1:0] i_pos_z,
    input  logic [sse_pkg::TIME_W-1:0]     i_time_ms,
    // result items
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_link_up,
    output logic [sse_pkg::SPEED_W-1:0]    o_speed,
    output logic                           o_moving,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sse_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [sse_pkg::CFG_W-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_ROOT, S_SCALE, S_DIV, S_BLEND, S_DECAY, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0]                   r_min_interval;
    logic [15:0]                   r_new_weight;
    logic [15:0]                   r_decay;
    logic [sse_pkg::SPEED_W-1:0]   r_zero_floor;
    logic [sse_pkg::SPEED_W-1:0]   r_moving_thr;

    // architectural state
    logic signed [sse_pkg::POS_W-1:0] r_last_x, r_last_y, r_last_z;
    logic [sse_pkg::TIME_W-1:0]    r_last_time;
    logic                          r_last_link;
    logic [sse_pkg::SPEED_W-1:0]   r_speed;

    // working registers
    logic [sse_pkg::POS_W-1:0]     r_dx, r_dy, r_dz;
    logic [sse_pkg::TIME_W-1:0]    r_dt;
    logic [sse_pkg::PROD_W-1:0]    r_acc;
    logic [sse_pkg::REM_W-1:0]     r_rem;
    logic [sse_pkg::ROOT_W-1:0]    r_root;
    logic [sse_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_link_in;

    // output register
    logic                          r_out_valid;
    logic                          r_out_link;
    logic [sse_pkg::SPEED_W-1:0]   r_out_speed;
    logic                          r_out_moving;

    logic                          in_acc;
    logic                          out_load;
    logic signed [sse_pkg::POS_W:0] dx_s, dy_s, dz_s;
    logic [sse_pkg::POS_W-1:0]     dx_mag, dy_mag, dz_mag;
    logic [sse_pkg::TIME_W-1:0]    dt;
    logic [sse_pkg::MUL_W-1:0]     mul_a, mul_b;
    logic [sse_pkg::PROD_W-1:0]    mul_p;
    logic [sse_pkg::POS_W-1:0]     sq_op;
    logic [sse_pkg::REM_W+1:0]     sq_rem_sh, sq_trial;
    logic                          sq_ge;
    logic [sse_pkg::POS_W:0]       div_rem_sh;
    logic                          div_ge;
    logic [sse_pkg::PROD_W-1:0]    blend_sum;
    logic [sse_pkg::SPEED_W-1:0]   blend_sat;
    logic [sse_pkg::SPEED_W-1:0]   spd_cand;
    logic [sse_pkg::SPEED_W-1:0]   n_speed;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    assign o_valid   = r_out_valid;
    assign o_link_up = r_out_link;
    assign o_speed   = r_out_speed;
    assign o_moving  = r_out_moving;

    // position deltas and time step
    always_comb begin
        dx_s   = $signed({i_pos_x[sse_pkg::POS_W-1], i_pos_x})
               - $signed({r_last_x[sse_pkg::POS_W-1], r_last_x});
        dy_s   = $signed({i_pos_y[sse_pkg::POS_W-1], i_pos_y})
               - $signed({r_last_y[sse_pkg::POS_W-1], r_last_y});
        dz_s   = $signed({i_pos_z[sse_pkg::POS_W-1], i_pos_z})
               - $signed({r_last_z[sse_pkg::POS_W-1], r_last_z});
        dx_mag = dx_s[sse_pkg::POS_W] ? sse_pkg::POS_W'(-dx_s) : dx_s[sse_pkg::POS_W-1:0];
        dy_mag = dy_s[sse_pkg::POS_W] ? sse_pkg::POS_W'(-dy_s) : dy_s[sse_pkg::POS_W-1:0];
        dz_mag = dz_s[sse_pkg::POS_W] ? sse_pkg::POS_W'(-dz_s) : dz_s[sse_pkg::POS_W-1:0];
        dt     = i_time_ms - r_last_time;
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_cnt[1:0])
            2'd0:    sq_op = r_dx;
            2'd1:    sq_op = r_dy;
            default: sq_op = r_dz;
        endcase
        unique case (r_state)
            S_SQ: begin
                mul_a = {1'b0, sq_op};
                mul_b = {1'b0, sq_op};
            end
            S_SCALE: begin
                mul_a = r_root;
                mul_b = sse_pkg::MUL_W'(sse_pkg::MS_PER_SEC);
            end
            S_BLEND: begin
                case (r_cnt[1:0])
                    2'd0: begin
                        mul_a = {1'b0, r_acc[31:0]};
                        mul_b = sse_pkg::MUL_W'(r_new_weight);
                    end
                    2'd1: begin
                        mul_a = sse_pkg::MUL_W'(r_acc[sse_pkg::NUM_W-1:32]);
                        mul_b = sse_pkg::MUL_W'(r_new_weight);
                    end
                    default: begin
                        mul_a = {1'b0, r_speed};
                        mul_b = sse_pkg::MUL_W'(sse_pkg::ONE_Q16 - {1'b0, r_new_weight});
                    end
                endcase
            end
            S_DECAY: begin
                mul_a = {1'b0, r_speed};
                mul_b = sse_pkg::MUL_W'(r_decay);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    sse_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // square root and division steps, blend and floor
    always_comb begin
        sq_rem_sh  = {r_rem, r_acc[sse_pkg::PROD_W-1 -: 2]};
        sq_trial   = {1'b0, r_root, 2'b01};
        sq_ge      = (sq_rem_sh >= sq_trial);
        div_rem_sh = {r_rem[sse_pkg::POS_W-1:0], r_acc[sse_pkg::NUM_W-1]};
        div_ge     = (div_rem_sh >= {1'b0, r_dt});
        blend_sum  = r_acc + mul_p;
        blend_sat  = (|blend_sum[sse_pkg::PROD_W-1:sse_pkg::FRAC_W+sse_pkg::SPEED_W])
                   ? '1 : blend_sum[sse_pkg::FRAC_W +: sse_pkg::SPEED_W];
        spd_cand   = (r_state == S_DECAY) ? mul_p[sse_pkg::FRAC_W +: sse_pkg::SPEED_W]
                                          : blend_sat;
        n_speed    = (spd_cand < r_zero_floor) ? '0 : spd_cand;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= sse_pkg::RST_MIN_INTERVAL;
            r_new_weight   <= sse_pkg::RST_NEW_WEIGHT;
            r_decay        <= sse_pkg::RST_DECAY;
            r_zero_floor   <= sse_pkg::RST_ZERO_FLOOR;
            r_moving_thr   <= sse_pkg::RST_MOVING_THR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sse_pkg::CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data[15:0];
                sse_pkg::CFG_NEW_WEIGHT:   r_new_weight   <= i_cfg_data[15:0];
                sse_pkg::CFG_DECAY:        r_decay        <= i_cfg_data[15:0];
                sse_pkg::CFG_ZERO_FLOOR:   r_zero_floor   <= i_cfg_data;
                sse_pkg::CFG_MOVING_THR:   r_moving_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_z     <= '0;
            r_last_time  <= '0;
            r_last_link  <= 1'b0;
            r_speed      <= '0;
            r_out_valid  <= 1'b0;
            r_out_link   <= 1'b0;
            r_out_speed  <= '0;
            r_out_moving <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_acc) begin
                        if (i_link_valid) begin
                            r_last_x    <= i_pos_x;
                            r_last_y    <= i_pos_y;
                            r_last_z    <= i_pos_z;
                            r_last_time <= i_time_ms;
                            r_last_link <= 1'b1;
                            if (!r_last_link) begin
                                r_speed <= '0;
                                r_state <= S_OUT;
                            end else if (dt >= {16'b0, r_min_interval}) begin
                                r_state <= S_SQ;
                            end else begin
                                r_state <= S_DECAY;
                            end
                        end else begin
                            r_last_link <= 1'b0;
                            r_state     <= S_OUT;
                        end
                    end
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == sse_pkg::CNT_W'(3)) begin
                        r_cnt   <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == sse_pkg::CNT_W'(sse_pkg::ROOT_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == sse_pkg::CNT_W'(1)) begin
                        r_cnt   <= '0;
                        r_state <= (r_dt == '0) ? S_BLEND : S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == sse_pkg::CNT_W'(sse_pkg::DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == sse_pkg::CNT_W'(3)) begin
                        r_speed <= n_speed;
                        r_state <= S_OUT;
                    end
                end
                S_DECAY: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == sse_pkg::CNT_W'(1)) begin
                        r_speed <= n_speed;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_link   <= r_link_in;
                        r_out_speed  <= r_speed;
                        r_out_moving <= (r_speed > r_moving_thr);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_link_in <= i_link_valid;
                    r_dx      <= dx_mag;
                    r_dy      <= dy_mag;
                    r_dz      <= dz_mag;
                    r_dt      <= dt;
                    r_acc     <= '0;
                end
            end
            S_SQ: begin
                if (r_cnt != '0) begin
                    r_acc <= r_acc + mul_p;
                end
                r_rem  <= '0;
                r_root <= '0;
            end
            S_ROOT: begin
                r_acc  <= r_acc << 2;
                r_rem  <= sq_ge ? sse_pkg::REM_W'(sq_rem_sh - sq_trial)
                                : sse_pkg::REM_W'(sq_rem_sh);
                r_root <= {r_root[sse_pkg::ROOT_W-2:0], sq_ge};
            end
            S_SCALE: begin
                r_rem <= '0;
                if (r_cnt == sse_pkg::CNT_W'(1)) begin
                    r_acc <= (r_dt == '0) ? '0
                           : {{(sse_pkg::PROD_W-sse_pkg::NUM_W){1'b0}},
                              mul_p[sse_pkg::NUM_W-1:0]};
                end
            end
            S_DIV: begin
                r_rem <= div_ge ? sse_pkg::REM_W'(div_rem_sh - {1'b0, r_dt})
                                : sse_pkg::REM_W'(div_rem_sh);
                r_acc <= {{(sse_pkg::PROD_W-sse_pkg::NUM_W){1'b0}},
                          r_acc[sse_pkg::NUM_W-2:0], div_ge};
            end
            S_BLEND: begin
                case (r_cnt[1:0])
                    2'd1:    r_acc <= mul_p;
                    2'd2:    r_acc <= r_acc + {mul_p[sse_pkg::MUL_W:0], 32'b0};
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("block not busy after taking an item");

    a_link_tracks_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_last_link == $past(i_link_valid)))
        else $error("last link flag does not follow the sample");

    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_cnt < sse_pkg::CNT_W'(sse_pkg::ROOT_STEPS)))
        else $error("square root step count out of range");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < sse_pkg::CNT_W'(sse_pkg::DIV_STEPS)))
        else $error("divide step count out of range");

endmodule
